// ----- design/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared types, codes, and size-class tables for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int FrameCount    = 16;
  localparam int ClassCount    = 12;
  localparam int WordsPerFrame = 128;
  localparam int BitmapDepth   = FrameCount * WordsPerFrame;
  localparam logic [4:0]  LinkNone   = 5'd31;
  localparam logic [15:0] SlotOrigin = 16'd1056;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadSize  = 2'd1,
    StNoFrame  = 2'd2,
    StBadFree  = 2'd3
  } status_e;

  typedef enum logic {
    KindAlloc = 1'b0,
    KindFree  = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [3:0]  free_frame;
    logic [12:0] free_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  size_class;
    logic [3:0]  frame_number;
    logic [12:0] slot_index;
    logic [15:0] byte_offset;
    logic        frame_released;
  } out_t;

  // Number of slots a slab of the given class holds.
  function automatic logic [12:0] cap_of(input logic [3:0] c);
    logic [12:0] n;
    case (c)
      4'd0:    n = 13'd5246;
      4'd1:    n = 13'd3934;
      4'd2:    n = 13'd2623;
      4'd3:    n = 13'd1573;
      4'd4:    n = 13'd874;
      4'd5:    n = 13'd462;
      4'd6:    n = 13'd238;
      4'd7:    n = 13'd121;
      4'd8:    n = 13'd61;
      4'd9:    n = 13'd30;
      4'd10:   n = 13'd15;
      4'd11:   n = 13'd7;
      4'd12:   n = 13'd3;
      4'd13:   n = 13'd1;
      default: n = 13'd0;
    endcase
    return n;
  endfunction

  // Distance between slots: object size plus the link bytes.
  function automatic logic [13:0] stride_of(input logic [3:0] c);
    logic [15:0] sz;
    sz = 16'd4 << c;
    return sz[13:0] + 14'd8;
  endfunction

  // Smallest class whose object size covers the request.
  function automatic logic [3:0] class_of(input logic [15:0] size);
    logic [3:0] c;
    logic       hit;
    c   = 4'd0;
    hit = 1'b0;
    for (int i = 0; i < ClassCount; i++) begin
      if (!hit && (size <= (16'd4 << i))) begin
        c   = 4'(i);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/soa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write when enabled, registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- design/slab_object_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Slab object allocator core
// Allocates and frees fixed-size objects in slabs of power-of-two classes.
// ----------------------------------------------------------------------------
// Usage: each input word on in_word_i is either an allocate (kind 0, with
// request_size) or a free (kind 1, with free_frame and free_index). Every
// accepted word produces exactly one result word on out_word_o.
// Words move on a valid/stall handshake: a word passes at a rising edge with
// valid high and stall low.
// The block works on one request at a time. in_stall_o stays high from the
// moment a request is taken until its result has been taken by the receiver.
// A rejected size or a free of an idle frame is answered from the idle
// state. A free whose slot is past the slab capacity passes SFChk, a free of
// a clear slot SFChk and SFRd, and a good free SFChk, SFRd, SMul and SOff,
// with SUl1 and SUl2 before SMul when the slab empties and is unlinked from
// its class list. An allocate walks past full slabs on the class list in
// SWalk, passes SLink when a fresh slab is linked behind a tail, reads and
// tests each 64-slot bitmap word in SRd and SChk, and ends in SMul and SOff;
// the bitmap word scan goes through the single RAM port.
// After reset all 2048 words of the slot bitmap RAM are cleared one word a
// cycle; no request is accepted until that pass is done.
// If the receiver stalls, the result word holds on out_word_o and no new
// request is taken until it leaves.
// ----------------------------------------------------------------------------
module slab_object_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  soa_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output soa_pkg::out_t out_word_o
);

  typedef enum logic [3:0] {
    SClr, SIdle, SWalk, SLink, SRd, SChk, SFChk, SFRd, SUl1, SUl2, SMul, SOff
  } state_e;

  localparam int AddrW = $clog2(soa_pkg::BitmapDepth);

  state_e        state_q;
  logic [AddrW-1:0] clr_q;
  logic [4:0]    head_q  [soa_pkg::ClassCount];
  logic [4:0]    next_q  [soa_pkg::FrameCount];
  logic [4:0]    prev_q  [soa_pkg::FrameCount];
  logic [15:0]   busy_q;
  logic [3:0]    owner_q [soa_pkg::FrameCount];
  logic [12:0]   fill_q  [soa_pkg::FrameCount];

  logic [3:0]    cls_q;
  logic [12:0]   cap_q;
  logic [4:0]    cur_q;
  logic [4:0]    tail_q;
  logic [4:0]    hops_q;
  logic [3:0]    frame_q;
  logic [6:0]    word_q;
  logic [12:0]   slot_q;
  logic [26:0]   prod_q;
  soa_pkg::out_t res_q;
  logic          out_valid_q;

  logic          ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  logic          accept;
  logic [3:0]    cur_idx;
  logic          idle_found;
  logic [3:0]    idle_frame;
  logic [5:0]    zero_bit;
  logic          word_full;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;
  assign cur_idx     = cur_q[3:0];
  assign word_full   = &ram_rdata;

  // Lowest idle frame in the pool.
  always_comb begin
    idle_found = 1'b0;
    idle_frame = 4'd0;
    for (int i = 0; i < soa_pkg::FrameCount; i++) begin
      if (!idle_found && !busy_q[i]) begin
        idle_found = 1'b1;
        idle_frame = 4'(i);
      end
    end
  end

  // Lowest clear bit of the bitmap word just read.
  always_comb begin
    logic hit;
    hit      = 1'b0;
    zero_bit = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (!hit && !ram_rdata[i]) begin
        hit      = 1'b1;
        zero_bit = 6'(i);
      end
    end
  end

  // The bitmap RAM sees one address per cycle, chosen by the sequencer step.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {frame_q, word_q};
    ram_wdata = ram_rdata;
    unique case (state_q)
      SClr: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      SChk: begin
        ram_we    = !word_full;
        ram_wdata = ram_rdata | (64'd1 << zero_bit);
      end
      SFChk: begin
        ram_addr = {frame_q, slot_q[12:6]};
      end
      SFRd: begin
        ram_addr  = {frame_q, slot_q[12:6]};
        ram_we    = ram_rdata[slot_q[5:0]];
        ram_wdata = ram_rdata & ~(64'd1 << slot_q[5:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  soa_ram #(
    .Width(64),
    .Depth(soa_pkg::BitmapDepth)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_q       <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < soa_pkg::ClassCount; i++) begin
        head_q[i] <= soa_pkg::LinkNone;
      end
      for (int i = 0; i < soa_pkg::FrameCount; i++) begin
        next_q[i]  <= soa_pkg::LinkNone;
        prev_q[i]  <= soa_pkg::LinkNone;
        owner_q[i] <= '0;
        fill_q[i]  <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SClr: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (accept) begin
            if (in_word_i.kind == soa_pkg::KindAlloc) begin
              if (in_word_i.request_size < 16'd4 || in_word_i.request_size > 16'd8192) begin
                res_q       <= {soa_pkg::StBadSize, 4'd0, 4'd0, 13'd0, 16'd0, 1'b0};
                out_valid_q <= 1'b1;
              end else begin
                res_q   <= '0;
                cls_q   <= soa_pkg::class_of(in_word_i.request_size);
                cap_q   <= soa_pkg::cap_of(soa_pkg::class_of(in_word_i.request_size));
                cur_q   <= head_q[soa_pkg::class_of(in_word_i.request_size)];
                tail_q  <= soa_pkg::LinkNone;
                hops_q  <= '0;
                state_q <= SWalk;
              end
            end else begin
              frame_q <= in_word_i.free_frame;
              slot_q  <= in_word_i.free_index;
              if (!busy_q[in_word_i.free_frame]) begin
                res_q       <= {soa_pkg::StBadFree, 4'd0, in_word_i.free_frame,
                                in_word_i.free_index, 16'd0, 1'b0};
                out_valid_q <= 1'b1;
              end else begin
                res_q   <= '0;
                cls_q   <= owner_q[in_word_i.free_frame];
                cap_q   <= soa_pkg::cap_of(owner_q[in_word_i.free_frame]);
                state_q <= SFChk;
              end
            end
          end
        end
        SWalk: begin
          // Follow the class list past full slabs.
          if (!cur_q[4] && fill_q[cur_idx] >= cap_q && !hops_q[4]) begin
            tail_q <= cur_q;
            cur_q  <= next_q[cur_idx];
            hops_q <= hops_q + 1'b1;
          end else if (!cur_q[4] && fill_q[cur_idx] < cap_q) begin
            frame_q <= cur_idx;
            word_q  <= '0;
            state_q <= SRd;
          end else if (!idle_found) begin
            res_q.status     <= soa_pkg::StNoFrame;
            res_q.size_class <= cls_q;
            out_valid_q      <= 1'b1;
            state_q          <= SIdle;
          end else begin
            // Append a fresh frame; its bitmap is already clear.
            busy_q[idle_frame]  <= 1'b1;
            owner_q[idle_frame] <= cls_q;
            fill_q[idle_frame]  <= '0;
            next_q[idle_frame]  <= soa_pkg::LinkNone;
            prev_q[idle_frame]  <= tail_q;
            frame_q             <= idle_frame;
            word_q              <= '0;
            if (tail_q[4]) begin
              head_q[cls_q] <= {1'b0, idle_frame};
              state_q       <= SRd;
            end else begin
              state_q <= SLink;
            end
          end
        end
        SLink: begin
          next_q[tail_q[3:0]] <= {1'b0, frame_q};
          state_q             <= SRd;
        end
        SRd: begin
          state_q <= SChk;
        end
        SChk: begin
          if (!word_full) begin
            fill_q[frame_q] <= fill_q[frame_q] + 1'b1;
            slot_q          <= {word_q, zero_bit};
            state_q         <= SMul;
          end else if (&word_q) begin
            res_q.status     <= soa_pkg::StNoFrame;
            res_q.size_class <= cls_q;
            out_valid_q      <= 1'b1;
            state_q          <= SIdle;
          end else begin
            word_q  <= word_q + 1'b1;
            state_q <= SRd;
          end
        end
        SFChk: begin
          if (slot_q >= cap_q) begin
            res_q.status       <= soa_pkg::StBadFree;
            res_q.frame_number <= frame_q;
            res_q.slot_index   <= slot_q;
            out_valid_q        <= 1'b1;
            state_q            <= SIdle;
          end else begin
            state_q <= SFRd;
          end
        end
        SFRd: begin
          if (!ram_rdata[slot_q[5:0]]) begin
            res_q.status       <= soa_pkg::StBadFree;
            res_q.frame_number <= frame_q;
            res_q.slot_index   <= slot_q;
            out_valid_q        <= 1'b1;
            state_q            <= SIdle;
          end else begin
            fill_q[frame_q] <= fill_q[frame_q] - 1'b1;
            if (fill_q[frame_q] == 13'd1) begin
              state_q <= SUl1;
            end else begin
              state_q <= SMul;
            end
          end
        end
        SUl1: begin
          // Bridge the predecessor (or the class head) over this slab.
          if (!prev_q[frame_q][4]) begin
            next_q[prev_q[frame_q][3:0]] <= next_q[frame_q];
          end else begin
            head_q[cls_q] <= next_q[frame_q];
          end
          state_q <= SUl2;
        end
        SUl2: begin
          if (!next_q[frame_q][4]) begin
            prev_q[next_q[frame_q][3:0]] <= prev_q[frame_q];
          end
          busy_q[frame_q]      <= 1'b0;
          owner_q[frame_q]     <= '0;
          next_q[frame_q]      <= soa_pkg::LinkNone;
          prev_q[frame_q]      <= soa_pkg::LinkNone;
          res_q.frame_released <= 1'b1;
          state_q              <= SMul;
        end
        SMul: begin
          prod_q  <= 27'(slot_q * soa_pkg::stride_of(cls_q));
          state_q <= SOff;
        end
        SOff: begin
          res_q.status       <= soa_pkg::StOk;
          res_q.size_class   <= cls_q;
          res_q.frame_number <= frame_q;
          res_q.slot_index   <= slot_q;
          res_q.byte_offset  <= prod_q[15:0] + soa_pkg::SlotOrigin;
          out_valid_q        <= 1'b1;
          state_q            <= SIdle;
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

// ----- test/tb_slab_object_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Slab object allocator core testbench
// Drives allocate and free words into the core, predicts every result with
// a behavioral slab model, and checks results in order on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Behavioral slab allocator plus the queue of predicted result words.
class slab_scoreboard;
  logic [4:0]  head_q[soa_pkg::ClassCount];
  logic [4:0]  next_q[soa_pkg::FrameCount];
  logic [4:0]  prev_q[soa_pkg::FrameCount];
  bit          busy_q[soa_pkg::FrameCount];
  logic [3:0]  owner_q[soa_pkg::FrameCount];
  int unsigned fill_q[soa_pkg::FrameCount];
  bit          slot_used[soa_pkg::FrameCount][8192];
  soa_pkg::out_t pending[$];
  int          errors;

  function new();
    for (int i = 0; i < soa_pkg::ClassCount; i++) head_q[i] = soa_pkg::LinkNone;
    for (int f = 0; f < soa_pkg::FrameCount; f++) begin
      next_q[f] = soa_pkg::LinkNone;
      prev_q[f] = soa_pkg::LinkNone;
      busy_q[f] = 0;
      owner_q[f] = 0;
      fill_q[f] = 0;
      for (int s = 0; s < 8192; s++) slot_used[f][s] = 0;
    end
    errors = 0;
  endfunction

  function int unsigned slots_in(int unsigned c);
    return (64000 - 1048) / ((4 << c) + 8);
  endfunction

  function logic [15:0] offset_in(int unsigned c, int unsigned s);
    int unsigned v;
    v = 1056 + s * ((4 << c) + 8);
    return v[15:0];
  endfunction

  function soa_pkg::out_t do_alloc(int unsigned size);
    soa_pkg::out_t r;
    int unsigned c, cap, f, tail, hops;
    r = '0;
    c = 0;
    tail = soa_pkg::LinkNone;
    hops = 0;
    if (size < 4 || size > 8192) begin
      r.status = soa_pkg::StBadSize;
      return r;
    end
    while ((4 << c) < size) c++;
    r.size_class = 4'(c);
    cap = slots_in(c);
    f = head_q[c];
    while (f < soa_pkg::FrameCount && fill_q[f] >= cap && hops < soa_pkg::FrameCount) begin
      tail = f;
      f = next_q[f];
      hops++;
    end
    if (!(f < soa_pkg::FrameCount) || fill_q[f] >= cap) begin
      for (f = 0; f < soa_pkg::FrameCount; f++) if (!busy_q[f]) break;
      if (f >= soa_pkg::FrameCount) begin
        r.status = soa_pkg::StNoFrame;
        return r;
      end
      busy_q[f] = 1;
      owner_q[f] = 4'(c);
      fill_q[f] = 0;
      for (int s = 0; s < 8192; s++) slot_used[f][s] = 0;
      next_q[f] = soa_pkg::LinkNone;
      prev_q[f] = 5'(tail);
      if (tail < soa_pkg::FrameCount) next_q[tail] = 5'(f);
      else head_q[c] = 5'(f);
    end
    for (int s = 0; s < 8192; s++) begin
      if (!slot_used[f][s]) begin
        slot_used[f][s] = 1;
        fill_q[f]++;
        r.status = soa_pkg::StOk;
        r.frame_number = 4'(f);
        r.slot_index = 13'(s);
        r.byte_offset = offset_in(c, s);
        return r;
      end
    end
    r.status = soa_pkg::StNoFrame;
    return r;
  endfunction

  function soa_pkg::out_t do_free(int unsigned f, int unsigned s);
    soa_pkg::out_t r;
    int unsigned c, p, n;
    r = '0;
    r.status = soa_pkg::StBadFree;
    r.frame_number = 4'(f);
    r.slot_index = 13'(s);
    if (!busy_q[f]) return r;
    c = owner_q[f];
    if (s >= slots_in(c) || !slot_used[f][s]) return r;
    slot_used[f][s] = 0;
    if (fill_q[f] > 0) fill_q[f]--;
    r.status = soa_pkg::StOk;
    r.size_class = 4'(c);
    r.byte_offset = offset_in(c, s);
    if (fill_q[f] == 0) begin
      p = prev_q[f];
      n = next_q[f];
      if (p < soa_pkg::FrameCount) next_q[p] = 5'(n);
      else head_q[c] = 5'(n);
      if (n < soa_pkg::FrameCount) prev_q[n] = 5'(p);
      busy_q[f] = 0;
      owner_q[f] = 0;
      next_q[f] = soa_pkg::LinkNone;
      prev_q[f] = soa_pkg::LinkNone;
      r.frame_released = 1;
    end
    return r;
  endfunction

  // Called for each accepted input word.
  function void note_request(soa_pkg::in_t w);
    if (w.kind == soa_pkg::KindAlloc) pending.push_back(do_alloc(w.request_size));
    else pending.push_back(do_free(w.free_frame, w.free_index));
  endfunction

  // Called for each accepted result word.
  function void check_result(soa_pkg::out_t got);
    soa_pkg::out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch expected st=%0d cls=%0d fr=%0d slot=%0d off=%0d rel=%0d",
               $time, want.status, want.size_class, want.frame_number,
               want.slot_index, want.byte_offset, want.frame_released);
      $display("%0t:          actual st=%0d cls=%0d fr=%0d slot=%0d off=%0d rel=%0d",
               $time, got.status, got.size_class, got.frame_number,
               got.slot_index, got.byte_offset, got.frame_released);
      errors++;
    end
  endfunction
endclass

module tb_slab_object_allocator_core;

  localparam int CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  soa_pkg::in_t  in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  soa_pkg::out_t out_word_o;

  // Idle and stall percentages for the current phase, and the length of a
  // long receiver hold-off; the receiver counts the hold-off cycles itself.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_count = 0;

  slab_scoreboard board;

  // Frames and slots granted so far, used to aim frees at live objects.
  logic [3:0]  live_frame[$];
  logic [12:0] live_slot[$];

  slab_object_allocator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: the clearing pass plus 633 slow requests fit far inside this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: samples at the rising edge, changes stall at the falling edge.
  // A requested hold-off keeps stall high for a counted stretch of cycles.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_word_o);
      if (out_word_o.status == soa_pkg::StOk && out_word_o.frame_released == 1'b0) begin
        // Remember fresh grants so later frees can target them.
        if (board.slot_used[out_word_o.frame_number][out_word_o.slot_index]) begin
          live_frame.push_back(out_word_o.frame_number);
          live_slot.push_back(out_word_o.slot_index);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cnt < hold_len) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one word, with a random gap before it, and waits for acceptance.
  // Valid stays high across the wait and into the next word; it only drops
  // on an idle gap or when the run is done.
  task automatic send_word(input soa_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(w);
    @(negedge clk_i);
  endtask

  task automatic send_alloc(input int unsigned size);
    soa_pkg::in_t w;
    w = '0;
    w.kind = soa_pkg::KindAlloc;
    w.request_size = 16'(size);
    // Unused fields carry noise so every input bit toggles.
    w.free_frame = 4'($urandom);
    w.free_index = 13'($urandom);
    send_word(w);
  endtask

  task automatic send_free(input int unsigned f, input int unsigned s);
    soa_pkg::in_t w;
    w = '0;
    w.kind = soa_pkg::KindFree;
    w.free_frame = 4'(f);
    w.free_index = 13'(s);
    w.request_size = 16'($urandom);
    send_word(w);
  endtask

  // Frees a random live object, dropping it from the list of grants.
  task automatic free_live();
    int unsigned k;
    logic [3:0]  f;
    logic [12:0] s;
    k = $urandom_range(live_frame.size() - 1);
    f = live_frame[k];
    s = live_slot[k];
    live_frame.delete(k);
    live_slot.delete(k);
    send_free(f, s);
  endtask

  // Sizes biased toward the large classes so slabs fill and the pool runs dry.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(3);
    if (r < 10) return $urandom_range(65535, 8193);
    if (r < 60) return $urandom_range(8192, 1025);
    return $urandom_range(1024, 4);
  endfunction

  task automatic random_items(input int unsigned count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) send_alloc(pick_size());
      else if (r < 90 && live_frame.size() > 0) free_live();
      else send_free($urandom_range(15), $urandom_range(8191));
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: size edges, rejected sizes, bad frees, a full slab of
    // the largest class, and release of an emptied slab.
    send_alloc(0);
    send_alloc(3);
    send_alloc(65535);
    send_alloc(8193);
    send_alloc(4);
    send_alloc(5);
    send_alloc(8192);
    send_free(15, 8191);
    send_free(0, 0);
    send_free(0, 0);
    send_free(0, 0);
    repeat (8) send_alloc(8192);
    send_free(1, 7);
    send_free(2, 0);
    send_free(1, 6);
    send_alloc(4096);

    // Random phases with different idle and stall mixes.
    random_items(150);
    send_idle_pct = 66;
    random_items(120);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    random_items(120);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_items(120);

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    random_items(100);
    in_valid_i <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
